>>> rtl/core/rmb_pkg.sv
// Shared types and constants for the raster mask boundary cell extractor.
// Used by the stage logic, the result queue and the top level.
// Depends on nothing.
package rmb_pkg;

    // Field and register widths.
    localparam int IDX_W     = 24;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    // Request operation codes.
    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Result queue sizing; the depth must be a power of two.
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
    } result_t;

    // Up to two results handed to the queue in one cycle, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Position flags of a request, worked out when it is accepted.
    typedef struct packed {
        logic valid;
        logic is_flush;
        logic sel;
        logic restart;
        logic row_first;
        logic row_one;
        logic col_first;
        logic col_one;
        logic col_last;
    } stage_ctl_t;

endpackage

>>> rtl/core/rmb_line_mem.sv
// Two one-bit line buffers held as one two-bit wide memory, one entry per column.
// Registered read with write-to-read forwarding on an address match.
// Depends on nothing.
module rmb_line_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [1:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [1:0]        rd_data
);

    // Bit 1 is the row two above, bit 0 the row above.
    logic [1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a same-cycle write to the same column is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data <= wr_data;
        end
        else
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/rmb_window.sv
// Decision stage: 3x3 window shift, line buffer update and boundary tests.
// Uses rmb_pkg; fed by the accept stage in the top level and the line memory.
module rmb_window #(
    parameter int COL_W  = 12,
    parameter int CDIM_W = 13
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  rmb_pkg::stage_ctl_t       ctl,
    input  logic [COL_W-1:0]          col,
    input  logic [rmb_pkg::IDX_W-1:0] idx,
    input  logic [CDIM_W-1:0]         cols,
    input  logic [1:0]                line_rd,
    output logic                      mem_wr_en,
    output logic [COL_W-1:0]          mem_wr_addr,
    output logic [1:0]                mem_wr_data,
    output rmb_pkg::push_t            push
);
    import rmb_pkg::*;

    logic [8:0]       win_reg;
    logic [8:0]       win_next;
    logic             above;
    logic             two_above;
    logic [IDX_W-1:0] idx_diag;
    logic [IDX_W-1:0] idx_up;
    logic [IDX_W-1:0] idx_flush;
    logic             hit_diag;
    logic             hit_up;

    assign above     = line_rd[0];
    assign two_above = line_rd[1];

    // New column enters at the top of the window: two above, above, current.
    assign win_next = {ctl.sel, above, two_above, win_reg[8:3]};

    // Indices of the candidate cells, modulo the index width.
    assign idx_diag  = idx - IDX_W'(cols) - IDX_W'(1);
    assign idx_up    = idx - IDX_W'(cols);
    assign idx_flush = idx - IDX_W'(cols) + IDX_W'(col);

    // The window centre is decided once it has a row and column before it.
    // Edge cells always count; inner cells count when any neighbour is clear.
    assign hit_diag = !ctl.row_first && !ctl.col_first && win_next[4]
                      && (ctl.row_one || ctl.col_one || (win_next != 9'h1FF));

    // The cell above a last-column cell lies on the right edge.
    assign hit_up = !ctl.row_first && ctl.col_last && above;

    // Line buffer update for raster cells.
    assign mem_wr_en   = ctl.valid && !ctl.is_flush;
    assign mem_wr_addr = col;
    assign mem_wr_data = {above, ctl.sel};

    // Pack the results in index order and flag the final one.
    always_comb
    begin
        push = '0;
        push.first.index  = idx_diag;
        push.second.index = idx_up;
        if (ctl.valid)
        begin
            if (ctl.is_flush)
            begin
                push.first.index = idx_flush;
                push.first.last  = 1'b1;
                push.count       = {1'b0, above};
            end
            else if (hit_diag && hit_up)
            begin
                push.second.last = 1'b1;
                push.count       = 2'd2;
            end
            else if (hit_diag)
            begin
                push.first.last = 1'b1;
                push.count      = 2'd1;
            end
            else if (hit_up)
            begin
                push.first.index = idx_up;
                push.first.last  = 1'b1;
                push.count       = 2'd1;
            end
        end
    end

    // Window state; cleared at frame restart.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (clear)
        begin
            win_reg <= '0;
        end
        else if (ctl.valid)
        begin
            if (ctl.is_flush)
            begin
                if (ctl.restart)
                begin
                    win_reg <= '0;
                end
            end
            else
            begin
                win_reg <= win_next;
            end
        end
    end

endmodule

>>> rtl/core/rmb_out_fifo.sv
// Result queue: up to two results in a cycle, one out a cycle if ready.
// Uses rmb_pkg for the result types and the queue depth.
module rmb_out_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rmb_pkg::push_t          push,
    input  logic                    pop_ready,
    output logic                    out_valid,
    output rmb_pkg::result_t        out_data,
    output logic [rmb_pkg::CNT_W-1:0] level
);
    import rmb_pkg::*;

    result_t          slots [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] level_reg;
    logic             pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = slots[head_reg];
    assign level     = level_reg;
    assign pop       = out_valid && pop_ready;

    // Storage writes at the tail.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slots[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slots[tail_reg + PTR_W'(1)] <= push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            tail_reg  <= tail_reg + PTR_W'(push.count);
            head_reg  <= head_reg + PTR_W'(pop);
            level_reg <= level_reg + CNT_W'(push.count) - CNT_W'(pop);
        end
    end

endmodule

>>> rtl/core/raster_mask_boundary_cells.sv
// Boundary cell extractor for a binary raster mask, 3x3 window, 8 neighbours.
//
// Requests arrive on item_valid/item_ready: op selects a raster cell (with its
// cell_selected flag, row-major order) or a flush tick; send one flush per
// column after the last cell. Results leave on result_valid/result_ready as
// cell_index values in ascending order, one row behind the input, with
// last_of_run set on the final result of each request. A request gives zero,
// one or two results.
// Throughput is one request per cycle while the queue has room. A request is
// accepted, its line buffer entry read from the column memory, and its results
// written to the result queue on the following edge. The eight-entry result
// queue sets how far the receiver may stall: item_ready drops when the queue
// could not take two more results for each request in flight, and nothing is
// lost while it is low.
// Reset clears the counters, the window and the queue; the line buffers are
// not cleared and need no clearing pass. Writing row_count or column_count
// restarts the frame and should only be done while the block is idle.
module raster_mask_boundary_cells #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          op,
    input  logic                          cell_selected,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [rmb_pkg::IDX_W-1:0]     cell_index,
    output logic                          last_of_run,
    input  logic                          cfg_write,
    input  logic [rmb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmb_pkg::CFG_W-1:0]     cfg_data
);
    import rmb_pkg::*;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CDIM_W = $clog2(MAX_COLUMNS + 1);
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);

    // Configuration and frame position.
    logic [RDIM_W-1:0] rows_reg;
    logic [CDIM_W-1:0] cols_reg;
    logic [RDIM_W-1:0] rows_sat;
    logic [CDIM_W-1:0] cols_sat;
    logic              cfg_hit;
    logic [COL_W-1:0]  col_reg;
    logic [RDIM_W-1:0] row_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Accept stage decode.
    logic              take;
    logic              col_ok;
    logic              row_in;
    logic [CDIM_W-1:0] col_inc;
    logic              col_wrap;
    logic              cell_go;
    logic              flush_go;
    logic [CNT_W:0]    reserve;

    // Decision stage inputs.
    stage_ctl_t        b_ctl_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [1:0]        line_rd;
    logic              mem_wr_en;
    logic [COL_W-1:0]  mem_wr_addr;
    logic [1:0]        mem_wr_data;
    push_t             push;
    result_t           head;
    logic [CNT_W-1:0]  fifo_level;

    // Register values of zero act as one; larger values saturate.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            rows_sat = RDIM_W'(1);
            cols_sat = CDIM_W'(1);
        end
        else
        begin
            if (32'(cfg_data) > 32'(MAX_ROWS))
            begin
                rows_sat = RDIM_W'(MAX_ROWS);
            end
            else
            begin
                rows_sat = RDIM_W'(cfg_data);
            end
            if (32'(cfg_data) > 32'(MAX_COLUMNS))
            begin
                cols_sat = CDIM_W'(MAX_COLUMNS);
            end
            else
            begin
                cols_sat = CDIM_W'(cfg_data);
            end
        end
    end

    assign cfg_hit = cfg_write
                     && ((cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COLUMN_COUNT));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RDIM_W'(1);
            cols_reg <= CDIM_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    rows_reg <= rows_sat;
                REG_COLUMN_COUNT: cols_reg <= cols_sat;
                default:          ;
            endcase
        end
    end

    // Space for two results per request in flight, plus this one.
    assign reserve    = (CNT_W + 1)'(fifo_level)
                        + (b_ctl_reg.valid ? (CNT_W + 1)'(4) : (CNT_W + 1)'(2));
    assign item_ready = (reserve <= (CNT_W + 1)'(FIFO_DEPTH));

    // Classify the request; out of place requests are taken and dropped.
    assign take     = item_valid && item_ready;
    assign col_ok   = (CDIM_W'(col_reg) < cols_reg);
    assign row_in   = (row_reg < rows_reg);
    assign col_inc  = CDIM_W'(col_reg) + CDIM_W'(1);
    assign col_wrap = (col_inc >= cols_reg);
    assign cell_go  = take && (op == OP_CELL) && row_in && col_ok;
    assign flush_go = take && (op == OP_FLUSH) && !row_in && col_ok;

    // Frame position counters; a register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            idx_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
            idx_reg <= '0;
        end
        else if (cell_go)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_reg + RDIM_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        else if (flush_go)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Hand-over register into the decision stage: control part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
        end
        else
        begin
            b_ctl_reg.valid     <= cell_go || flush_go;
            b_ctl_reg.is_flush  <= (op == OP_FLUSH);
            b_ctl_reg.sel       <= cell_selected;
            b_ctl_reg.restart   <= col_wrap;
            b_ctl_reg.row_first <= (row_reg == '0);
            b_ctl_reg.row_one   <= (row_reg == RDIM_W'(1));
            b_ctl_reg.col_first <= (col_reg == '0);
            b_ctl_reg.col_one   <= (col_reg == COL_W'(1));
            b_ctl_reg.col_last  <= col_wrap;
        end
    end

    // Hand-over register: position payload.
    always_ff @(posedge clk)
    begin
        b_col_reg <= col_reg;
        b_idx_reg <= idx_reg;
    end

    rmb_line_mem #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    rmb_window #(
        .COL_W  (COL_W),
        .CDIM_W (CDIM_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cfg_hit),
        .ctl         (b_ctl_reg),
        .col         (b_col_reg),
        .idx         (b_idx_reg),
        .cols        (cols_reg),
        .line_rd     (line_rd),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .push        (push)
    );

    rmb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop_ready (result_ready),
        .out_valid (result_valid),
        .out_data  (head),
        .level     (fifo_level)
    );

    assign cell_index  = head.index;
    assign last_of_run = head.last;

    // The queue always has room for what the decision stage pushes.
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(fifo_level) + (CNT_W + 1)'(push.count)
         <= (CNT_W + 1)'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // A register write sends the frame back to its first cell.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> ((col_reg == '0) && (row_reg == '0) && (idx_reg == '0)))
        else $error("frame not restarted after register write");

    // A flush before the raster is complete is dropped.
    a_early_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (op == OP_FLUSH) && row_in) |=> !b_ctl_reg.valid)
        else $error("early flush reached the decision stage");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for raster_mask_boundary_cells: directed and random frames,
// scored against a cycle-free predictor of the boundary cell results.
// Depends on rmb_pkg and the raster_mask_boundary_cells RTL.
module tb_top;

    import rmb_pkg::*;

    localparam int MAX_ROWS      = 4096;
    localparam int MAX_COLS      = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int PROFILE_ITEMS = 275;
    localparam int WIDE_COLS     = 160;
    localparam int TALL_ROWS     = 120;

    // Clock, reset and block ports.
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 item_valid    = 1'b0;
    logic                 item_ready;
    logic                 item_op       = OP_CELL;
    logic                 item_sel      = 1'b0;
    logic                 result_valid;
    logic                 result_ready  = 1'b0;
    logic [IDX_W-1:0]     cell_index;
    logic                 last_of_run;
    logic                 cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_ROW_COUNT;
    logic [CFG_W-1:0]     cfg_data      = '0;

    // Idle percentages of the sender and of the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Predictor state: registers, line buffers, window and frame position.
    logic [CFG_W-1:0] row_reg = 13'd1;
    logic [CFG_W-1:0] col_reg = 13'd1;
    bit               above_row     [MAX_COLS];
    bit               two_above_row [MAX_COLS];
    logic [8:0]       window    = '0;
    int unsigned      cur_row   = 0;
    int unsigned      cur_col   = 0;
    logic [IDX_W-1:0] run_index = '0;

    // Boundary cells predicted and not yet seen at the output.
    result_t pending_boundary_q[$];

    // Run statistics.
    int unsigned requests_sent    = 0;
    int unsigned results_checked  = 0;
    int unsigned mismatch_count   = 0;
    int unsigned frame_items      = 0;
    int unsigned frames_completed = 0;
    int unsigned frames_abandoned = 0;
    int unsigned stall_cycles     = 0;

    raster_mask_boundary_cells #(
        .MAX_COLUMNS(MAX_COLS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (item_op),
        .cell_selected(item_sel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cell_index   (cell_index),
        .last_of_run  (last_of_run),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // A register value of zero acts as one; large values saturate.
    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v == 0)
        begin
            return 1;
        end
        return (v > maxv) ? maxv : int'(v);
    endfunction

    task automatic restart_frame();
        window    = '0;
        cur_row   = 0;
        cur_col   = 0;
        run_index = '0;
    endtask

    // Works out the boundary cells that one accepted request reveals.
    task automatic predict_boundary_cells(input logic req_op, input logic req_sel);
        int unsigned      rows;
        int unsigned      cols;
        int unsigned      r;
        int unsigned      c;
        int unsigned      n;
        logic [IDX_W-1:0] found [2];
        bit               la;
        bit               l2;
        result_t          res;
        rows = eff_dim(row_reg, MAX_ROWS);
        cols = eff_dim(col_reg, MAX_COLS);
        r    = cur_row;
        c    = cur_col;
        n    = 0;
        if (req_op == OP_FLUSH)
        begin
            // Flush ticks only count once the whole raster is in.
            if (r < rows || c >= cols)
            begin
                return;
            end
            if (above_row[c])
            begin
                found[n] = run_index - IDX_W'(cols) + IDX_W'(c);
                n++;
            end
            if (c + 1 >= cols)
            begin
                restart_frame();
            end
            else
            begin
                cur_col = c + 1;
            end
        end
        else
        begin
            // Cells after the last row wait for the flush and are dropped.
            if (r >= rows || c >= cols)
            begin
                return;
            end
            la               = above_row[c];
            l2               = two_above_row[c];
            two_above_row[c] = la;
            above_row[c]     = req_sel;
            window           = {req_sel, la, l2, window[8:3]};
            // The window center is cell (r-1, c-1).
            if (r >= 1 && c >= 1 && window[4])
            begin
                if (r == 1 || c == 1 || r - 1 == rows - 1 || window != 9'h1FF)
                begin
                    found[n] = run_index - IDX_W'(cols) - 1'b1;
                    n++;
                end
            end
            // The last column of the row above is an edge cell.
            if (r >= 1 && c == cols - 1 && la)
            begin
                found[n] = run_index - IDX_W'(cols);
                n++;
            end
            run_index = run_index + 1'b1;
            if (c + 1 >= cols)
            begin
                cur_col = 0;
                cur_row = r + 1;
            end
            else
            begin
                cur_col = c + 1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            res.index = found[i];
            res.last  = (i == n - 1);
            pending_boundary_q.insert(pending_boundary_q.size(), res);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Receiver: stalls at random according to the current profile.
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Scoreboard: checks each result and predicts each accepted request.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_boundary_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, cell_index %0d", cell_index));
                end
                else
                begin
                    want = pending_boundary_q.pop_front();
                    if (cell_index !== want.index)
                    begin
                        report_mismatch($sformatf("result %0d: cell_index %0d, expected %0d",
                                                  results_checked, cell_index, want.index));
                    end
                    if (last_of_run !== want.last)
                    begin
                        report_mismatch($sformatf("result %0d: last_of_run %b, expected %b",
                                                  results_checked, last_of_run, want.last));
                    end
                end
                results_checked++;
            end
            if (item_valid && item_ready)
            begin
                predict_boundary_cells(item_op, item_sel);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no request or result accepted for %0d cycles", STALL_LIMIT);
                $display("raster_mask_boundary_cells regression: fail");
                $finish;
            end
        end
    end

    // Sends one request, with a random gap first, and waits for its acceptance.
    task automatic send_item(input logic req_op, input logic req_sel);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item_op    <= req_op;
        item_sel   <= req_sel;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // Lets every expected result drain and the pipeline settle.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_boundary_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both dimension registers on back-to-back edges; this restarts the frame.
    task automatic configure(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
        cfg_write <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= rows_val;
        @(posedge clk);
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= cols_val;
        @(posedge clk);
        cfg_write <= 1'b0;
        row_reg = rows_val;
        col_reg = cols_val;
        restart_frame();
    endtask

    // One frame with random content; stray flushes and cells are mixed in as noise.
    task automatic send_frame(input int unsigned rows, input int unsigned cols,
                              input int unsigned density, input bit truncate);
        int unsigned stop;
        stop = truncate ? $urandom_range(0, rows * cols - 1) : rows * cols;
        for (int unsigned i = 0; i < stop; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
            end
            send_item(OP_CELL, $urandom_range(0, 99) < density);
            frame_items++;
        end
        if (truncate)
        begin
            frames_abandoned++;
            return;
        end
        for (int unsigned k = 0; k < cols; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(OP_CELL, 1'($urandom_range(0, 1)));
            end
            send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
            frame_items++;
        end
        frames_completed++;
    endtask

    // Power-up registers give a 1x1 raster; also early flush and late cell.
    task automatic test_reset_defaults();
        send_item(OP_FLUSH, 1'b1);
        send_item(OP_CELL, 1'b1);
        send_item(OP_CELL, 1'b0);
        send_item(OP_FLUSH, 1'b0);
        send_item(OP_CELL, 1'b0);
        send_item(OP_FLUSH, 1'b1);
        wait_idle();
    endtask

    // Zero acts as one, and values past the maximum saturate.
    task automatic test_register_extremes();
        configure(13'd0, 13'd0);
        send_item(OP_CELL, 1'b1);
        send_item(OP_FLUSH, 1'b0);
        wait_idle();
        configure(13'd4096, 13'd8191);
        repeat (3) send_item(OP_CELL, 1'b1);
        wait_idle();
    endtask

    // A full 3x3 mask: only the center is interior, and one cell gives two results.
    task automatic test_window_directed();
        configure(13'd3, 13'd3);
        repeat (9) send_item(OP_CELL, 1'b1);
        repeat (3) send_item(OP_FLUSH, 1'b0);
        wait_idle();
    endtask

    // Random small frames under each idle profile.
    task automatic test_random_frames();
        int unsigned rows_val;
        int unsigned cols_val;
        int unsigned density;
        int unsigned budget;
        bit          truncate;
        bit          reconfig;
        for (int profile = 0; profile < 3; profile++)
        begin
            case (profile)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            budget   = frame_items + PROFILE_ITEMS;
            reconfig = 1'b1;
            while (frame_items < budget)
            begin
                if (reconfig || $urandom_range(0, 3) != 0)
                begin
                    rows_val = $urandom_range(1, 6);
                    cols_val = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                           : $urandom_range(1, 8);
                    if (rows_val == 1 && $urandom_range(0, 1) == 1)
                    begin
                        rows_val = 0;
                    end
                    if (cols_val == 1 && $urandom_range(0, 1) == 1)
                    begin
                        cols_val = 0;
                    end
                    wait_idle();
                    configure(CFG_W'(rows_val), CFG_W'(cols_val));
                end
                case ($urandom_range(0, 5))
                    0:       density = 100;
                    1:       density = 0;
                    2:       density = 90;
                    3, 4:    density = 60;
                    default: density = 25;
                endcase
                truncate = ($urandom_range(0, 9) == 0);
                send_frame(eff_dim(row_reg, MAX_ROWS), eff_dim(col_reg, MAX_COLS),
                           density, truncate);
                reconfig = truncate;
            end
        end
    endtask

    // Long rows and tall columns: one wide two-row frame and one single-column frame.
    task automatic test_wide_frames();
        wait_idle();
        configure(13'd2, CFG_W'(WIDE_COLS));
        repeat (2 * WIDE_COLS) send_item(OP_CELL, 1'($urandom_range(0, 1)));
        repeat (3) send_item(OP_CELL, 1'b1);
        repeat (WIDE_COLS) send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
        wait_idle();
        configure(CFG_W'(TALL_ROWS), 13'd1);
        repeat (TALL_ROWS) send_item(OP_CELL, $urandom_range(0, 9) != 0);
        repeat (2) send_item(OP_CELL, 1'b1);
        send_item(OP_FLUSH, 1'b0);
        send_item(OP_FLUSH, 1'b1);
        frames_completed += 2;
    endtask

    // Test sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 24;
        recv_idle_pct = 72;
        test_reset_defaults();
        test_register_extremes();
        test_window_directed();
        test_random_frames();
        test_wide_frames();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d requests in %0d complete and %0d abandoned frames.",
                 requests_sent, frames_completed, frames_abandoned);
        $display("Checked %0d boundary results across three idle profiles.", results_checked);
        if (pending_boundary_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_boundary_q.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("raster_mask_boundary_cells regression: pass");
        end
        else
        begin
            $display("raster_mask_boundary_cells regression: fail");
        end
        $finish;
    end

endmodule
